// ----- src/datetime_difference_seconds_macros.svh -----
// Assertion helpers shared by the datetime difference block.
// Each check samples on clk and is disabled while arst_n is low.
`ifndef DATETIME_DIFFERENCE_SECONDS_MACROS_SVH
`define DATETIME_DIFFERENCE_SECONDS_MACROS_SVH

`ifndef SYNTHESIS
`define DDS_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define DDS_NEVER(lbl, cond, msg) \
	`DDS_CHECK(lbl, !(cond), msg)
`else
`define DDS_CHECK(lbl, prop, msg)
`define DDS_NEVER(lbl, cond, msg)
`endif

`endif

// ----- src/dds_pkg.sv -----
package dds_pkg;

	// field widths of one transaction
	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int SECS_W  = 6;
	localparam int STAT_W  = 3;
	localparam int DUR_W   = 39;

	// largest year accepted as valid
	localparam int MAX_YEAR = 9999;

	// default depth of the queue between front and back
	localparam int DEFAULT_QUEUE_DEPTH = 4;

	// internal widths
	localparam int CENT_W = 8;   // year / 100
	localparam int REM_W  = 7;   // year % 100
	localparam int LEAP_W = 12;  // leap days before a year
	localparam int DOY_W  = 9;   // day of year, from 0
	localparam int DAYS_W = 23;  // days since the epoch
	localparam int TOD_W  = 17;  // seconds of the day

	// reciprocal of 100, exact for every 14-bit year
	localparam int RECIP_100   = 5243;
	localparam int RECIP_SHIFT = 19;
	localparam int PROD_W      = YEAR_W + 13;

	localparam int DAYS_PER_YEAR = 365;
	localparam int SEC_PER_DAY   = 86400;
	localparam int SEC_PER_HOUR  = 3600;
	localparam int SEC_PER_MIN   = 60;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 3'd0,
		ST_BAD_SDATE = 3'd1,
		ST_BAD_STIME = 3'd2,
		ST_BAD_EDATE = 3'd3,
		ST_BAD_ETIME = 3'd4,
		ST_REVERSED  = 3'd5
	} status_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [HOUR_W-1:0]  hour;
		logic [MIN_W-1:0]   minute;
		logic [SECS_W-1:0]  second;
	} raw_t;

	typedef struct packed {
		logic [YEAR_W-1:0] year;
		logic [LEAP_W-1:0] leaps;
		logic [DOY_W-1:0]  doy;
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
		logic [SECS_W-1:0] second;
	} side_t;

	typedef struct packed {
		status_t status;
		side_t   start_side;
		side_t   end_side;
	} entry_t;

	// year / 100 by reciprocal multiply
	function automatic logic [CENT_W-1:0] cent_of(input logic [YEAR_W-1:0] y);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(y) * PROD_W'(RECIP_100);
		return prod[RECIP_SHIFT +: CENT_W];
	endfunction

	// days in a month; zero for a month code out of range
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic lp);
		logic [DAY_W-1:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = lp ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	// days before the first of a month in a common year
	function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] m);
		logic [DOY_W-1:0] ds;
		case (m)
			4'd1:    ds = 9'd0;
			4'd2:    ds = 9'd31;
			4'd3:    ds = 9'd59;
			4'd4:    ds = 9'd90;
			4'd5:    ds = 9'd120;
			4'd6:    ds = 9'd151;
			4'd7:    ds = 9'd181;
			4'd8:    ds = 9'd212;
			4'd9:    ds = 9'd243;
			4'd10:   ds = 9'd273;
			4'd11:   ds = 9'd304;
			4'd12:   ds = 9'd334;
			default: ds = 9'd0;
		endcase
		return ds;
	endfunction

endpackage

// ----- src/dds_front.sv -----
`include "datetime_difference_seconds_macros.svh"

module dds_front import dds_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	output logic   full,
	input  raw_t   start_in,
	input  raw_t   end_in,
	output logic   wr_en,
	input  logic   wr_full,
	output entry_t wr_data
);

	typedef struct packed {
		logic  date_ok;
		logic  time_ok;
		side_t side;
	} check_t;

	// validate one date-time and reduce it to year, leap days, day of year and time of day
	function automatic check_t check_side(input raw_t r, input logic [CENT_W-1:0] q);
		logic [YEAR_W:0]   rem_w;
		logic [REM_W-1:0]  rem;
		logic              lp;
		logic [DAY_W-1:0]  len;
		logic [YEAR_W-1:0] lc;
		check_t            c;
		rem_w = (YEAR_W+1)'(r.year) - (YEAR_W+1)'(q) * (YEAR_W+1)'(100);
		rem   = rem_w[REM_W-1:0];
		lp    = (r.year[1:0] == 2'b00) && ((rem != '0) || (q[1:0] == 2'b00));
		len   = month_len(r.month, lp);
		c.date_ok = (32'(r.year) <= 32'(MAX_YEAR)) && (r.day != '0) && (r.day <= len);
		c.time_ok = (r.hour <= 5'd23) && (r.minute <= 6'd59) && (r.second <= 6'd59);
		// leap days in years 0 .. y-1: ceil(y/4) - ceil(y/100) + ceil(y/400)
		lc = YEAR_W'(r.year[YEAR_W-1:2]) + YEAR_W'(r.year[1:0] != 2'b00)
			+ YEAR_W'(q[CENT_W-1:2]) + YEAR_W'((q[1:0] != 2'b00) || (rem != '0))
			- YEAR_W'(q) - YEAR_W'(rem != '0);
		c.side.year   = r.year;
		c.side.leaps  = lc[LEAP_W-1:0];
		c.side.doy    = month_start(r.month) + DOY_W'(r.month > 4'd2 && lp)
			+ DOY_W'(r.day) - DOY_W'(1);
		c.side.hour   = r.hour;
		c.side.minute = r.minute;
		c.side.second = r.second;
		return c;
	endfunction

	logic              v_s1;
	raw_t              st_s1;
	raw_t              en_s1;
	logic [CENT_W-1:0] sq_s1;
	logic [CENT_W-1:0] eq_s1;
	logic              go_s1;
	check_t            sc;
	check_t            ec;

	// stage holds while the queue is full
	assign go_s1 = !v_s1 || !wr_full;
	assign full  = !go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (go_s1) begin
			v_s1 <= push;
		end
	end

	// capture the transaction and divide the years by 100
	always_ff @(posedge clk) begin
		if (go_s1 && push) begin
			st_s1 <= start_in;
			en_s1 <= end_in;
			sq_s1 <= cent_of(start_in.year);
			eq_s1 <= cent_of(end_in.year);
		end
	end

	// classify: first fault wins
	always_comb begin
		sc = check_side(st_s1, sq_s1);
		ec = check_side(en_s1, eq_s1);
		wr_data.start_side = sc.side;
		wr_data.end_side   = ec.side;
		if (!sc.date_ok) begin
			wr_data.status = ST_BAD_SDATE;
		end else if (!sc.time_ok) begin
			wr_data.status = ST_BAD_STIME;
		end else if (!ec.date_ok) begin
			wr_data.status = ST_BAD_EDATE;
		end else if (!ec.time_ok) begin
			wr_data.status = ST_BAD_ETIME;
		end else begin
			wr_data.status = ST_OK;
		end
	end

	assign wr_en = v_s1 && !wr_full;

	`DDS_NEVER(front_full_without_item, full && !v_s1, "front stalls with no item held")

endmodule

// ----- src/dds_fifo.sv -----
`include "datetime_difference_seconds_macros.svh"

module dds_fifo import dds_pkg::*; #(
	parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  entry_t wr_data,
	output logic   full,
	output logic   rd_valid,
	input  logic   rd_en,
	output entry_t rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t        mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];

	// store the written entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// advance pointers and track fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CW'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	`DDS_NEVER(fifo_overflow, wr_en && full, "write into a full queue")
	`DDS_NEVER(fifo_underflow, rd_en && !rd_valid, "read from an empty queue")
	`DDS_CHECK(fifo_count_range, count_q <= CW'(DEPTH), "queue count beyond depth")

endmodule

// ----- src/dds_back.sv -----
`include "datetime_difference_seconds_macros.svh"

module dds_back import dds_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_valid,
	output logic             rd_en,
	input  entry_t           rd_data,
	input  logic             pop,
	output logic             empty,
	output logic [STAT_W-1:0] status,
	output logic [DUR_W-1:0] duration_seconds
);

	function automatic logic [DAYS_W-1:0] day_count(input side_t s);
		return DAYS_W'(s.year) * DAYS_W'(DAYS_PER_YEAR) + DAYS_W'(s.leaps) + DAYS_W'(s.doy);
	endfunction

	function automatic logic [TOD_W-1:0] tod_of(input side_t s);
		return TOD_W'(s.hour) * TOD_W'(SEC_PER_HOUR) + TOD_W'(s.minute) * TOD_W'(SEC_PER_MIN)
			+ TOD_W'(s.second);
	endfunction

	logic              v_s2, v_s3, v_s4;
	logic              go2, go3, go4;
	status_t           status_s2, status_s3, status_s4;
	logic [DAYS_W-1:0] sdays_s2, edays_s2;
	logic [TOD_W-1:0]  stod_s2, etod_s2;
	logic [DUR_W-1:0]  ssec_s3, esec_s3;
	logic [DUR_W-1:0]  dur_s4;
	logic [DUR_W:0]    diff;

	// each stage loads when empty or when its item moves on
	assign go4   = !v_s4 || pop;
	assign go3   = !v_s3 || go4;
	assign go2   = !v_s2 || go3;
	assign rd_en = rd_valid && go2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (go2) begin
				v_s2 <= rd_valid;
			end
			if (go3) begin
				v_s3 <= v_s2;
			end
			if (go4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// day counts and seconds of the day
	always_ff @(posedge clk) begin
		if (rd_en) begin
			status_s2 <= rd_data.status;
			sdays_s2  <= day_count(rd_data.start_side);
			edays_s2  <= day_count(rd_data.end_side);
			stod_s2   <= tod_of(rd_data.start_side);
			etod_s2   <= tod_of(rd_data.end_side);
		end
	end

	// absolute seconds since the epoch
	always_ff @(posedge clk) begin
		if (go3 && v_s2) begin
			status_s3 <= status_s2;
			ssec_s3   <= DUR_W'(sdays_s2) * DUR_W'(SEC_PER_DAY) + DUR_W'(stod_s2);
			esec_s3   <= DUR_W'(edays_s2) * DUR_W'(SEC_PER_DAY) + DUR_W'(etod_s2);
		end
	end

	// borrow of end minus start flags a reversed range
	assign diff = {1'b0, esec_s3} - {1'b0, ssec_s3};

	always_ff @(posedge clk) begin
		if (go4 && v_s3) begin
			if (status_s3 != ST_OK) begin
				status_s4 <= status_s3;
				dur_s4    <= '0;
			end else if (diff[DUR_W]) begin
				status_s4 <= ST_REVERSED;
				dur_s4    <= '0;
			end else begin
				status_s4 <= ST_OK;
				dur_s4    <= diff[DUR_W-1:0];
			end
		end
	end

	assign empty            = !v_s4;
	assign status           = status_s4;
	assign duration_seconds = dur_s4;

	`DDS_CHECK(err_has_zero_dur, (v_s4 && status_s4 != ST_OK) |-> (dur_s4 == '0), "error with duration")
	`DDS_CHECK(s3_held_on_stall, (v_s3 && !go4) |=> v_s3, "stalled item lost in back end")

endmodule

// ----- src/datetime_difference_seconds.sv -----
// Throughput: one transaction per cycle unless an unpopped result stalls,
// set by the one-stage front and the three-stage back end joined by a small
// register queue.
// Reset: arst_n clears every valid bit and the queue pointers at once; no clearing
// pass, the block takes a transaction right after reset is released.
module datetime_difference_seconds import dds_pkg::*; #(
	parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [YEAR_W-1:0]  start_year,
	input  logic [MONTH_W-1:0] start_month,
	input  logic [DAY_W-1:0]   start_day,
	input  logic [HOUR_W-1:0]  start_hour,
	input  logic [MIN_W-1:0]   start_minute,
	input  logic [SECS_W-1:0]  start_second,
	input  logic [YEAR_W-1:0]  end_year,
	input  logic [MONTH_W-1:0] end_month,
	input  logic [DAY_W-1:0]   end_day,
	input  logic [HOUR_W-1:0]  end_hour,
	input  logic [MIN_W-1:0]   end_minute,
	input  logic [SECS_W-1:0]  end_second,
	output logic               empty,
	input  logic               pop,
	output logic [STAT_W-1:0]  status,
	output logic [DUR_W-1:0]   duration_seconds
);

	raw_t   start_in;
	raw_t   end_in;
	logic   wr_en;
	logic   wr_full;
	entry_t wr_data;
	logic   rd_valid;
	logic   rd_en;
	entry_t rd_data;

	// group the port fields of each date-time
	assign start_in = '{year: start_year, month: start_month, day: start_day,
		hour: start_hour, minute: start_minute, second: start_second};
	assign end_in   = '{year: end_year, month: end_month, day: end_day,
		hour: end_hour, minute: end_minute, second: end_second};

	dds_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.start_in(start_in),
		.end_in  (end_in),
		.wr_en   (wr_en),
		.wr_full (wr_full),
		.wr_data (wr_data)
	);

	dds_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.full    (wr_full),
		.rd_valid(rd_valid),
		.rd_en   (rd_en),
		.rd_data (rd_data)
	);

	dds_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.rd_valid        (rd_valid),
		.rd_en           (rd_en),
		.rd_data         (rd_data),
		.pop             (pop),
		.empty           (empty),
		.status          (status),
		.duration_seconds(duration_seconds)
	);

endmodule
